/* design/fsq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsq_pkg
// Types and constants shared by the squaring pipeline modules.
// ----------------------------------------------------------------------------
package fsq_pkg;

  localparam int LimbBits  = 56;
  localparam int TopBits   = 52;
  localparam int NumLimbs  = 8;
  localparam int FoldMul   = 17;
  localparam int HalfBits  = LimbBits / 2;
  localparam int ProdBits  = 2 * LimbBits;
  localparam int ColBits   = 128;
  localparam int NumPairs  = NumLimbs * (NumLimbs + 1) / 2;

  typedef logic [LimbBits-1:0]   limb_t;
  typedef logic [ProdBits-1:0]   prod_t;
  typedef logic [ColBits-1:0]    col_t;
  typedef col_t [NumLimbs:0]     cols_t;

  typedef struct packed {
    limb_t in_limb_0;
    limb_t in_limb_1;
    limb_t in_limb_2;
    limb_t in_limb_3;
    limb_t in_limb_4;
    limb_t in_limb_5;
    limb_t in_limb_6;
    limb_t in_limb_7;
  } in_t;

  typedef struct packed {
    logic [LimbBits-1:0] out_limb_0;
    logic [LimbBits:0]   out_limb_1;
    logic [LimbBits-1:0] out_limb_2;
    logic [LimbBits-1:0] out_limb_3;
    logic [LimbBits-1:0] out_limb_4;
    logic [LimbBits-1:0] out_limb_5;
    logic [LimbBits-1:0] out_limb_6;
    logic [LimbBits-1:0] out_limb_7;
    logic [TopBits-1:0]  out_limb_8;
  } out_t;

  // flat slot of the product f_i * f_j for i <= j
  function automatic int pidx(input int i, input int j);
    return i * NumLimbs - (i * (i - 1)) / 2 + (j - i);
  endfunction

endpackage

/* design/fsq_mul_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsq_mul_cell
// Two-stage 56x56 multiplier built from four registered 28x28 products.
// ----------------------------------------------------------------------------
module fsq_mul_cell
  import fsq_pkg::*;
(
  input  logic  clk,
  input  logic  en,
  input  limb_t a,
  input  limb_t b,
  output prod_t p
);

  logic [LimbBits-1:0] pll;
  logic [LimbBits-1:0] plh;
  logic [LimbBits-1:0] phl;
  logic [LimbBits-1:0] phh;

  always_ff @(posedge clk) begin
    if (en) begin
      pll <= a[HalfBits-1:0]        * b[HalfBits-1:0];
      plh <= a[HalfBits-1:0]        * b[LimbBits-1:HalfBits];
      phl <= a[LimbBits-1:HalfBits] * b[HalfBits-1:0];
      phh <= a[LimbBits-1:HalfBits] * b[LimbBits-1:HalfBits];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= {{LimbBits{1'b0}}, pll}
         + ({{LimbBits{1'b0}}, plh} << HalfBits)
         + ({{LimbBits{1'b0}}, phl} << HalfBits)
         + ({phh, {LimbBits{1'b0}}});
    end
  end

endmodule

/* design/fsq_carry_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsq_carry_cell
// One step of the carry chain: moves the carry of column IDX into IDX+1.
// ----------------------------------------------------------------------------
module fsq_carry_cell
  import fsq_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic  clk,
  input  logic  en,
  input  cols_t cin,
  output cols_t cout
);

  cols_t nxt;

  always_comb begin
    nxt          = cin;
    nxt[IDX + 1] = cin[IDX + 1] + (cin[IDX] >> LimbBits);
    nxt[IDX]     = {{(ColBits-LimbBits){1'b0}}, cin[IDX][LimbBits-1:0]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cout <= nxt;
    end
  end

endmodule

/* design/field_square_mod_2p444_minus_17.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// field_square_mod_2p444_minus_17
// Squaring modulo 2^444-17 over eight 56-bit limbs, fully pipelined.
// ----------------------------------------------------------------------------
// throughput: one element per cycle unless stalled; 36 pipelined mul cells
// stages: 2 multiply, 1 column sum, 8 carry cells, 1 fold
// the whole pipeline holds only while the final result is stalled
// reset clears the stage valid bits; data registers are not reset
module field_square_mod_2p444_minus_17
  import fsq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int NumStages = 12;

  logic                 en;
  logic [NumStages-1:0] vld;
  limb_t                f [NumLimbs];
  prod_t                prod [NumPairs];
  cols_t                chain [NumLimbs+1];
  cols_t                colsum_next;
  logic [63:0]          top;
  logic [11:0]          top_hi;
  logic [LimbBits:0]    r0;
  logic [LimbBits:0]    r1;

  assign en       = !(vld[NumStages-1] && out_stall);
  assign in_stall = !en;
  assign out_valid = vld[NumStages-1];

  assign f[0] = in_data.in_limb_0;
  assign f[1] = in_data.in_limb_1;
  assign f[2] = in_data.in_limb_2;
  assign f[3] = in_data.in_limb_3;
  assign f[4] = in_data.in_limb_4;
  assign f[5] = in_data.in_limb_5;
  assign f[6] = in_data.in_limb_6;
  assign f[7] = in_data.in_limb_7;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NumStages-2:0], in_valid};
    end
  end

  for (genvar i = 0; i < NumLimbs; i++) begin : g_row
    for (genvar j = i; j < NumLimbs; j++) begin : g_col
      fsq_mul_cell u_mul (
        .clk (clk),
        .en  (en),
        .a   (f[i]),
        .b   (f[j]),
        .p   (prod[pidx(i, j)])
      );
    end
  end

  function automatic col_t ext(input prod_t x);
    return {{(ColBits-ProdBits){1'b0}}, x};
  endfunction

  function automatic col_t pp(input int i, input int j);
    return ext(prod[pidx(i, j)]);
  endfunction

  // fold factors: 2^448 = 272 mod p, cross terms doubled
  function automatic col_t m544(input col_t x);
    return (x << 9) + (x << 5);
  endfunction

  function automatic col_t m272(input col_t x);
    return (x << 8) + (x << 4);
  endfunction

  always_comb begin
    colsum_next    = '0;
    colsum_next[0] = pp(0,0) + m544(pp(1,7) + pp(2,6) + pp(3,5)) + m272(pp(4,4));
    colsum_next[1] = (pp(0,1) << 1) + m544(pp(2,7) + pp(3,6) + pp(4,5));
    colsum_next[2] = (pp(0,2) << 1) + pp(1,1) + m544(pp(3,7) + pp(4,6)) + m272(pp(5,5));
    colsum_next[3] = ((pp(0,3) + pp(1,2)) << 1) + m544(pp(4,7) + pp(5,6));
    colsum_next[4] = ((pp(0,4) + pp(1,3)) << 1) + pp(2,2) + m544(pp(5,7))
                   + m272(pp(6,6));
    colsum_next[5] = ((pp(0,5) + pp(1,4) + pp(2,3)) << 1) + m544(pp(6,7));
    colsum_next[6] = ((pp(0,6) + pp(1,5) + pp(2,4)) << 1) + pp(3,3) + m272(pp(7,7));
    colsum_next[7] = (pp(0,7) + pp(1,6) + pp(2,5) + pp(3,4)) << 1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      chain[0] <= colsum_next;
    end
  end

  for (genvar k = 0; k < NumLimbs; k++) begin : g_carry
    fsq_carry_cell #(.IDX(k)) u_carry (
      .clk  (clk),
      .en   (en),
      .cin  (chain[k]),
      .cout (chain[k+1])
    );
  end

  // top limb split at bit 52, high part times 17 back into limb 0
  assign top    = chain[NumLimbs][NumLimbs][63:0];
  assign top_hi = top[63:TopBits];
  assign r0     = {1'b0, chain[NumLimbs][0][LimbBits-1:0]}
                + {{(LimbBits-16){1'b0}}, {5'b0, top_hi} + ({5'b0, top_hi} << 4)};
  assign r1     = {1'b0, chain[NumLimbs][1][LimbBits-1:0]}
                + {{LimbBits{1'b0}}, r0[LimbBits]};

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.out_limb_0 <= r0[LimbBits-1:0];
      out_data.out_limb_1 <= r1;
      out_data.out_limb_2 <= chain[NumLimbs][2][LimbBits-1:0];
      out_data.out_limb_3 <= chain[NumLimbs][3][LimbBits-1:0];
      out_data.out_limb_4 <= chain[NumLimbs][4][LimbBits-1:0];
      out_data.out_limb_5 <= chain[NumLimbs][5][LimbBits-1:0];
      out_data.out_limb_6 <= chain[NumLimbs][6][LimbBits-1:0];
      out_data.out_limb_7 <= chain[NumLimbs][7][LimbBits-1:0];
      out_data.out_limb_8 <= top[TopBits-1:0];
    end
  end

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  a_hold_valids: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("stage valids moved during a hold");

  a_fill: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> vld[0])
    else $error("accepted transfer not tracked in first stage");

endmodule
